@@ hw/rtl/pai_pkg.sv @@
// Package for the Pareto archive: command and status codes, controller command and status structs.
`timescale 1ns / 1ps
package pai_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DOMINATED = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_CLEARED   = 3'd3;
  localparam logic [2:0] ST_DUMP      = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam int TAG_W = 16;
  localparam int OBJ_W = 32;
  localparam int MAX_OBJ = 4;

  typedef struct packed {
    logic       idle;
    logic       clr_idx;
    logic       rd;
    logic       inc_i;
    logic       wr_keep;
    logic       wr_new;
    logic       set_cnt_w;
    logic       clr_cnt;
    logic       emit;
    logic       emit_entry;
    logic       emit_last;
    logic [2:0] emit_code;
  } ctrl_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_cmd;
    logic       i_end;
    logic       count_zero;
    logic       dom_old;
    logic       dom_new;
    logic       w_full;
    logic       dump_last;
    logic       out_free;
  } sts_t;

endpackage

@@ hw/rtl/pai_in_if.sv @@
// Input item channel of the Pareto archive.
`timescale 1ns / 1ps
interface pai_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [15:0]        solution_tag;
  logic signed [31:0] obj_0;
  logic signed [31:0] obj_1;
  logic signed [31:0] obj_2;
  logic signed [31:0] obj_3;
  modport source (output valid, command, solution_tag, obj_0, obj_1, obj_2, obj_3,
                  input ready);
  modport sink (input valid, command, solution_tag, obj_0, obj_1, obj_2, obj_3,
                output ready);
endinterface

@@ hw/rtl/pai_out_if.sv @@
// Result item channel of the Pareto archive.
`timescale 1ns / 1ps
interface pai_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [5:0]         entry_count;
  logic [15:0]        out_tag;
  logic signed [31:0] out_obj_0;
  logic signed [31:0] out_obj_1;
  logic signed [31:0] out_obj_2;
  logic signed [31:0] out_obj_3;
  logic               last;
  modport source (output valid, status, entry_count, out_tag, out_obj_0, out_obj_1,
                  out_obj_2, out_obj_3, last, input ready);
  modport sink (input valid, status, entry_count, out_tag, out_obj_0, out_obj_1,
                out_obj_2, out_obj_3, last, output ready);
endinterface

@@ hw/rtl/pai_cfg_if.sv @@
// Configuration write channel of the Pareto archive (objective mask).
`timescale 1ns / 1ps
interface pai_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hw/rtl/pai_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pai_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

@@ hw/rtl/pai_ctrl.sv @@
// Controller state machine for the Pareto archive: scan, compact, append, clear, dump.
`timescale 1ns / 1ps
module pai_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  pai_pkg::sts_t s,
  output pai_pkg::ctrl_t c
);
  import pai_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_CLEAR     = 10'b0000000010,
    S_SCAN_RD   = 10'b0000000100,
    S_SCAN_CHK  = 10'b0000001000,
    S_CMP_RD    = 10'b0000010000,
    S_CMP_CHK   = 10'b0000100000,
    S_APPEND    = 10'b0001000000,
    S_RESP      = 10'b0010000000,
    S_DUMP_RD   = 10'b0100000000,
    S_DUMP_WAIT = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_INSERTED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    c         = '0;
    c.emit_code = code_r;
    unique case (state_r)
      S_IDLE: begin
        c.idle = 1'b1;
        if (s.in_valid) begin
          unique case (s.in_cmd)
            CMD_INSERT: state_nxt = S_SCAN_RD;
            CMD_CLEAR:  state_nxt = S_CLEAR;
            CMD_DUMP:   state_nxt = S_DUMP_RD;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        c.clr_cnt = 1'b1;
        code_nxt  = ST_CLEARED;
        state_nxt = S_RESP;
      end
      S_SCAN_RD: begin
        if (s.i_end) begin
          c.clr_idx = 1'b1;
          state_nxt = S_CMP_RD;
        end else begin
          c.rd      = 1'b1;
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (s.dom_old) begin
          code_nxt  = ST_DOMINATED;
          state_nxt = S_RESP;
        end else begin
          c.inc_i   = 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_CMP_RD: begin
        if (s.i_end) begin
          c.set_cnt_w = 1'b1;
          state_nxt   = S_APPEND;
        end else begin
          c.rd      = 1'b1;
          state_nxt = S_CMP_CHK;
        end
      end
      S_CMP_CHK: begin
        // keep survivors, drop entries the new item dominates
        c.wr_keep = !s.dom_new;
        c.inc_i   = 1'b1;
        state_nxt = S_CMP_RD;
      end
      S_APPEND: begin
        if (s.w_full) begin
          code_nxt = ST_FULL;
        end else begin
          c.wr_new = 1'b1;
          code_nxt = ST_INSERTED;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (s.out_free) begin
          c.emit      = 1'b1;
          c.emit_last = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        if (s.count_zero) begin
          code_nxt  = ST_EMPTY;
          state_nxt = S_RESP;
        end else begin
          c.rd      = 1'b1;
          state_nxt = S_DUMP_WAIT;
        end
      end
      S_DUMP_WAIT: begin
        c.emit_code = ST_DUMP;
        if (s.out_free) begin
          c.emit       = 1'b1;
          c.emit_entry = 1'b1;
          c.emit_last  = s.dump_last;
          c.inc_i      = 1'b1;
          state_nxt    = s.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

@@ hw/rtl/pai_dp.sv @@
// Datapath for the Pareto archive: entry store, dominance compare, indexes, output register.
`timescale 1ns / 1ps
module pai_dp #(
  parameter int CAPACITY       = 32,
  parameter int NUM_OBJECTIVES = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pai_pkg::ctrl_t c,
  output pai_pkg::sts_t  s,
  pai_in_if.sink         in_ch,
  pai_out_if.source      out_ch,
  pai_cfg_if.sink        cfg_ch
);
  import pai_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int DW    = TAG_W + NUM_OBJECTIVES * OBJ_W;

  logic [3:0]       mask_r;
  logic [CNT_W-1:0] count_r, i_r, w_r;
  logic [DW-1:0]    new_r, new_word, rd_word, wdata;
  logic             out_valid_r;
  logic [2:0]       status_r;
  logic [5:0]       ecount_r;
  logic [15:0]      tag_r;
  logic signed [31:0] oobj_r [MAX_OBJ];
  logic signed [31:0] in_obj [MAX_OBJ];
  logic signed [31:0] rd_obj [MAX_OBJ];
  logic [NUM_OBJECTIVES-1:0] act_mask;
  logic [CNT_W+5:0] cnt_ext;
  logic             accept;

  assign accept = c.idle && in_ch.valid;
  assign in_ch.ready  = c.idle;
  assign cfg_ch.ready = 1'b1;

  assign in_obj[0] = in_ch.obj_0;
  assign in_obj[1] = in_ch.obj_1;
  assign in_obj[2] = in_ch.obj_2;
  assign in_obj[3] = in_ch.obj_3;

  assign new_word[TAG_W-1:0] = in_ch.solution_tag;
  for (genvar k = 0; k < MAX_OBJ; k++) begin : g_obj
    if (k < NUM_OBJECTIVES) begin : g_used
      assign new_word[TAG_W+OBJ_W*k +: OBJ_W] = in_obj[k];
      assign rd_obj[k] = rd_word[TAG_W+OBJ_W*k +: OBJ_W];
    end else begin : g_unused
      assign rd_obj[k] = '0;
    end
  end

  always_comb begin
    act_mask = mask_r[NUM_OBJECTIVES-1:0];
    if (act_mask == '0) begin
      act_mask = '1;
    end
  end

  function automatic logic dominates(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                     input logic [NUM_OBJECTIVES-1:0] m);
    logic le;
    logic lt;
    logic signed [31:0] x;
    logic signed [31:0] y;
    le = 1'b1;
    lt = 1'b0;
    for (int k = 0; k < NUM_OBJECTIVES; k++) begin
      x = a[TAG_W+OBJ_W*k +: OBJ_W];
      y = b[TAG_W+OBJ_W*k +: OBJ_W];
      if (m[k]) begin
        if (x > y) le = 1'b0;
        if (x < y) lt = 1'b1;
      end
    end
    return le && lt;
  endfunction

  assign wdata = c.wr_new ? new_r : rd_word;

  pai_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (c.wr_keep || c.wr_new),
    .waddr (w_r[AW-1:0]),
    .wdata (wdata),
    .re    (c.rd),
    .raddr (i_r[AW-1:0]),
    .rdata (rd_word)
  );

  always_comb begin
    s            = '0;
    s.in_valid   = in_ch.valid;
    s.in_cmd     = in_ch.command;
    s.i_end      = (i_r == count_r);
    s.count_zero = (count_r == '0);
    s.dom_old    = dominates(rd_word, new_r, act_mask);
    s.dom_new    = dominates(new_r, rd_word, act_mask);
    s.w_full     = (w_r == CNT_W'(CAPACITY));
    s.dump_last  = (CNT_W'(i_r + 1'b1) == count_r);
    s.out_free   = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      count_r     <= '0;
      i_r         <= '0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        mask_r <= cfg_ch.data;
      end
      if (accept || c.clr_idx) begin
        i_r <= '0;
        w_r <= '0;
      end else begin
        if (c.inc_i) i_r <= CNT_W'(i_r + 1'b1);
        if (c.wr_keep) w_r <= CNT_W'(w_r + 1'b1);
      end
      if (c.clr_cnt) begin
        count_r <= '0;
      end else if (c.set_cnt_w) begin
        count_r <= w_r;
      end else if (c.wr_new) begin
        count_r <= CNT_W'(w_r + 1'b1);
      end
      if (c.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign cnt_ext = {6'd0, count_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      new_r <= new_word;
    end
    if (c.emit) begin
      status_r <= c.emit_code;
      ecount_r <= cnt_ext[5:0];
      tag_r    <= c.emit_entry ? rd_word[TAG_W-1:0] : 16'd0;
      for (int j = 0; j < MAX_OBJ; j++) begin
        oobj_r[j] <= c.emit_entry ? rd_obj[j] : 32'sd0;
      end
    end
  end

  logic last_r;
  always_ff @(posedge clk) begin
    if (c.emit) begin
      last_r <= c.emit_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.entry_count = ecount_r;
  assign out_ch.out_tag     = tag_r;
  assign out_ch.out_obj_0   = oobj_r[0];
  assign out_ch.out_obj_1   = oobj_r[1];
  assign out_ch.out_obj_2   = oobj_r[2];
  assign out_ch.out_obj_3   = oobj_r[3];
  assign out_ch.last        = last_r;
endmodule

@@ hw/rtl/pareto_archive_insert.sv @@
// Pareto archive top level: usage notes, controller and datapath, assertions.
// Channels: in_ch takes one command item (insert, clear, dump) when valid and
// ready are high; out_ch gives result items; cfg_ch writes the 4-bit objective
// mask and is always ready. Write the mask only while the block is idle.
// Insert: a scan pass checks whether any stored entry dominates the new one; if
// none does, a compaction pass rewrites the survivors in order through the
// one-write, one-read entry RAM, then the append and response follow.
// Dump: one result per entry; an empty archive gives one result with status
// archive empty. A command code of 3 is accepted and gives no result.
// in_ch.ready is high only while the controller is idle; one item at a time.
// Results sit in an output register; a stalled receiver holds the controller
// in its response state, and a new item is taken while the last result waits.
// Reset empties the archive and clears the mask; the entry RAM is not cleared,
// since only entries below the count are ever read.
`timescale 1ns / 1ps
module pareto_archive_insert #(
  parameter int CAPACITY       = 32,
  parameter int NUM_OBJECTIVES = 4
) (
  input logic       clk,
  input logic       rst_n,
  pai_in_if.sink    in_ch,
  pai_out_if.source out_ch,
  pai_cfg_if.sink   cfg_ch
);
  import pai_pkg::*;

  ctrl_t c;
  sts_t  s;

  pai_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .s     (s),
    .c     (c)
  );

  pai_dp #(.CAPACITY(CAPACITY), .NUM_OBJECTIVES(NUM_OBJECTIVES)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .c      (c),
    .s      (s),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    c.emit |-> s.out_free)
    else $error("result loaded over an untaken result");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(c.wr_keep && c.wr_new))
    else $error("two store writes in one cycle");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.command != CMD_NONE)
    |=> !in_ch.ready)
    else $error("item taken while previous item still at work");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    c.emit |-> !c.idle)
    else $error("result emitted from idle");
endmodule

@@ bench/pai_tb_if.sv @@
// Testbench note: the channel interfaces come from the RTL; this file holds the archive item struct.
`timescale 1ns / 1ps
package pai_tb_pkg;
  import pai_pkg::*;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         entry_count;
    logic [15:0]        tag;
    logic signed [31:0] o0;
    logic signed [31:0] o1;
    logic signed [31:0] o2;
    logic signed [31:0] o3;
    logic               last;
  } archive_result_t;
endpackage

@@ bench/pai_checker.sv @@
// Checker for the Pareto archive: watches the channels, predicts results and compares them.
`timescale 1ns / 1ps
module pai_checker #(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst_n,
  pai_in_if    in_ch,
  pai_out_if   out_ch,
  pai_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import pai_pkg::*;
  import pai_tb_pkg::*;

  logic signed [31:0] arch_obj [CAPACITY][4];
  logic [15:0]        arch_tag [CAPACITY];
  int                 arch_count;
  logic [3:0]         obj_mask;
  archive_result_t    expected_q[$];

  assign pending = expected_q.size();

  function automatic void add_expected(input archive_result_t r);
    expected_q = {expected_q, r};
  endfunction

  function automatic bit beats(input logic signed [31:0] a[4], input logic signed [31:0] b[4],
                               input logic [3:0] m);
    bit strict;
    strict = 0;
    for (int k = 0; k < 4; k++) begin
      if (m[k]) begin
        if (a[k] > b[k]) return 0;
        if (a[k] < b[k]) strict = 1;
      end
    end
    return strict;
  endfunction

  function automatic archive_result_t short_result(input logic [2:0] st);
    archive_result_t r;
    r = '0;
    r.status = st;
    r.entry_count = arch_count[5:0];
    r.last = 1'b1;
    return r;
  endfunction

  task automatic predict_archive(input logic [1:0] cmd, input logic [15:0] tag,
                                 input logic signed [31:0] nv[4]);
    logic [3:0]      m;
    int              w;
    bit              hit;
    archive_result_t r;
    m = (obj_mask == 4'd0) ? 4'hF : obj_mask;
    hit = 0;
    w = 0;
    if (cmd == CMD_CLEAR) begin
      arch_count = 0;
      add_expected(short_result(ST_CLEARED));
    end else if (cmd == CMD_DUMP) begin
      if (arch_count == 0) add_expected(short_result(ST_EMPTY));
      for (int i = 0; i < arch_count; i++) begin
        r = '0;
        r.status = ST_DUMP;
        r.entry_count = arch_count[5:0];
        r.tag = arch_tag[i];
        r.o0 = arch_obj[i][0];
        r.o1 = arch_obj[i][1];
        r.o2 = arch_obj[i][2];
        r.o3 = arch_obj[i][3];
        r.last = (i + 1 == arch_count);
        add_expected(r);
      end
    end else if (cmd == CMD_INSERT) begin
      for (int i = 0; i < arch_count; i++)
        if (beats(arch_obj[i], nv, m)) hit = 1;
      if (hit) begin
        add_expected(short_result(ST_DOMINATED));
      end else begin
        for (int i = 0; i < arch_count; i++) begin
          if (!beats(nv, arch_obj[i], m)) begin
            arch_obj[w] = arch_obj[i];
            arch_tag[w] = arch_tag[i];
            w++;
          end
        end
        arch_count = w;
        if (arch_count >= CAPACITY) begin
          add_expected(short_result(ST_FULL));
        end else begin
          arch_obj[arch_count] = nv;
          arch_tag[arch_count] = tag;
          arch_count++;
          add_expected(short_result(ST_INSERTED));
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    archive_result_t  e;
    logic signed [31:0] nv[4];
    if (!rst_n) begin
      arch_count = 0;
      obj_mask   = '0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) obj_mask = cfg_ch.data;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result, status %0d", out_ch.status);
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          compare_field("status", e.status, out_ch.status);
          compare_field("entry_count", e.entry_count, out_ch.entry_count);
          compare_field("out_tag", e.tag, out_ch.out_tag);
          compare_field("out_obj_0", e.o0, out_ch.out_obj_0);
          compare_field("out_obj_1", e.o1, out_ch.out_obj_1);
          compare_field("out_obj_2", e.o2, out_ch.out_obj_2);
          compare_field("out_obj_3", e.o3, out_ch.out_obj_3);
          compare_field("last", e.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        nv[0] = in_ch.obj_0;
        nv[1] = in_ch.obj_1;
        nv[2] = in_ch.obj_2;
        nv[3] = in_ch.obj_3;
        predict_archive(in_ch.command, in_ch.solution_tag, nv);
      end
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the Pareto archive: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb;
  import pai_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   hold_out = 0;
  bit   sending_done = 0;

  pai_in_if  in_ch();
  pai_out_if out_ch();
  pai_cfg_if cfg_ch();

  pareto_archive_insert dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                             .cfg_ch(cfg_ch));

  pai_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                   .cfg_ch(cfg_ch), .fail_count(fail_count), .pending(pending));

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.command = CMD_INSERT;
    in_ch.solution_tag = 0;
    in_ch.obj_0 = 0;
    in_ch.obj_1 = 0;
    in_ch.obj_2 = 0;
    in_ch.obj_3 = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
  end

  // Receiver: random stalls per item, plus one long hold-off.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_ch.ready = 0;
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        out_ch.ready = 0;
        repeat (gap) @(negedge clk);
        out_ch.ready = 1;
        do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || (sending_done && pending == 0))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic [15:0] tag,
                           input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] d,
                           input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    repeat (gap) @(negedge clk);
    in_ch.valid = 1;
    in_ch.command = cmd;
    in_ch.solution_tag = tag;
    in_ch.obj_0 = a;
    in_ch.obj_1 = b;
    in_ch.obj_2 = c;
    in_ch.obj_3 = d;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_mask(input logic [3:0] m);
    wait_drained();
    cfg_ch.valid = 1;
    cfg_ch.data = m;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid = 0;
  endtask

  // Small values collide often, which makes dominance and ties common.
  function automatic logic [31:0] pick_obj();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 12) - 6;
    endcase
  endfunction

  task automatic random_item(input bit no_gap);
    int          r;
    logic [1:0]  cmd;
    r = $urandom_range(0, 99);
    if (r < 82) cmd = CMD_INSERT;
    else if (r < 86) cmd = CMD_CLEAR;
    else if (r < 96) cmd = CMD_DUMP;
    else cmd = CMD_NONE;
    send_item(cmd, $urandom(), pick_obj(), pick_obj(), pick_obj(), pick_obj(), no_gap);
  endtask

  initial begin
    logic [3:0] masks [6] = '{4'h0, 4'hF, 4'h1, 4'h5, 4'hA, 4'h8};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: empty dump, extremes, equal solutions, dominance both ways.
    send_item(CMD_DUMP, 0, 0, 0, 0, 0, 0);
    send_item(CMD_INSERT, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 0);
    send_item(CMD_INSERT, 16'h0000, 5, 5, 5, 5, 0);
    send_item(CMD_INSERT, 16'h1234, 5, 5, 5, 5, 0);
    send_item(CMD_INSERT, 16'h0001, 6, 5, 5, 5, 0);
    send_item(CMD_INSERT, 16'h0002, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 0);
    send_item(CMD_INSERT, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 0, 0);
    send_item(CMD_NONE, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA, 0, 32'hFFFF_FFFF, 0);
    send_item(CMD_DUMP, 0, 0, 0, 0, 0, 0);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(CMD_DUMP, 0, 0, 0, 0, 0, 0);
    // Fill to capacity with a non-dominated diagonal, then hit the full case.
    for (int i = 0; i < 33; i++)
      send_item(CMD_INSERT, i, i, 40 - i, 0, 0, 1);
    send_item(CMD_DUMP, 0, 0, 0, 0, 0, 1);
    send_item(CMD_INSERT, 16'h00FF, 3, 100, 0, 0, 1);

    // Long hold-off on the receiver while the sender keeps offering items.
    hold_out = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_out = 0;
      end
      for (int i = 0; i < 6; i++) random_item(1);
    join
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_mask(masks[p]);
      for (int i = 0; i < 45; i++) random_item(i < 10);
      if (p == 2) send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      send_item(CMD_DUMP, 0, 0, 0, 0, 0, 0);
    end

    sending_done = 1;
    wait_drained();
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pai_pkg.sv
hw/rtl/pai_in_if.sv
hw/rtl/pai_out_if.sv
hw/rtl/pai_cfg_if.sv
hw/rtl/pai_ram.sv
hw/rtl/pai_ctrl.sv
hw/rtl/pai_dp.sv
hw/rtl/pareto_archive_insert.sv
bench/pai_tb_if.sv
bench/pai_checker.sv
bench/tb.sv
